// ===== rtl/lfbp_pkg.sv =====
// Shared types and constants for the LSB-first pair bit packer.
package lfbp_pkg;

    localparam int CODE_W        = 16;
    localparam int SYM_W         = 8;
    localparam int LEN_W         = 5;
    localparam int BYTE_W        = 8;
    localparam int PEND_W        = 7;
    localparam int PCNT_W        = 3;
    localparam int ACC_W         = 31;
    localparam int TOTAL_W       = 5;
    localparam int MAX_CODE_BITS = 16;
    localparam int LEN_LIMIT     = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
    localparam int MAX_BYTES     = 3;

    localparam logic MODE_PAIR  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [CODE_W-1:0] code;
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  bit_length;
    } t_item;

    typedef struct packed {
        logic [1:0]                         nbytes;
        logic [MAX_BYTES-1:0][BYTE_W-1:0]   bytes;
    } t_pack_res;

endpackage

// ===== rtl/lsb_first_pair_bit_packer.sv =====
// Top level of the LSB-first pair bit packer.
// The input channel (i_valid, o_stall) takes one item per transfer: a pair
// (i_mode low) appends the low i_bit_length bits of i_code, saturated to 16,
// and then the 8 bits of i_sym; a flush (i_mode high) sends the pending
// partial byte, padded with zeros, if any bits are pending.
// The output channel (o_valid, i_stall) carries one packed byte per transfer,
// earliest bit in bit 0, with o_last marking the final byte of an item.
// An accepted item is held in the input register until the byte buffer is
// free; it is then loaded into the byte buffer, which shows its first byte
// on the output.
// The output port moves one byte per cycle while the receiver does not stall,
// so an item that yields n bytes occupies the output for n transfers (one
// to three); without stalls, items that yield no or one byte go one per cycle.
// While the receiver stalls, the byte buffer holds and the input register
// fills, after which o_stall is raised until the buffer can take the item.
// Reset empties the accumulator, the input register and the byte buffer.
module lsb_first_pair_bit_packer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_mode,
    input  logic [lfbp_pkg::CODE_W-1:0] i_code,
    input  logic [lfbp_pkg::SYM_W-1:0]  i_sym,
    input  logic [lfbp_pkg::LEN_W-1:0]  i_bit_length,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [lfbp_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_last
);

    logic                r_in_valid;
    lfbp_pkg::t_item     r_item;
    lfbp_pkg::t_pack_res pack_res;
    logic                buf_free;
    logic                load;
    logic                in_fire;

    assign load    = r_in_valid && buf_free;
    assign o_stall = r_in_valid && !buf_free;
    assign in_fire = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= '{mode: i_mode, code: i_code, sym: i_sym, bit_length: i_bit_length};
        end
    end

    lfbp_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_item  (r_item),
        .o_res   (pack_res)
    );

    lfbp_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_res      (pack_res),
        .i_stall    (i_stall),
        .o_free     (buf_free),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && o_valid)
        else $error("Input stalled with no item waiting or no byte pending.");

    a_idle_out_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !o_valid |=> !r_in_valid || $past(in_fire))
        else $error("A waiting item was not loaded into an empty buffer.");

endmodule

// ===== rtl/lfbp_pack.sv =====
// Bit accumulator: holds the pending partial byte and splits one item into bytes.
module lfbp_pack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  lfbp_pkg::t_item     i_item,
    output lfbp_pkg::t_pack_res o_res
);

    localparam logic [lfbp_pkg::LEN_W-1:0] LenLimit = lfbp_pkg::LEN_W'(lfbp_pkg::LEN_LIMIT);

    logic [lfbp_pkg::PEND_W-1:0]  r_pend_bits, n_pend_bits;
    logic [lfbp_pkg::PCNT_W-1:0]  r_pend_cnt, n_pend_cnt;

    logic [lfbp_pkg::LEN_W-1:0]   len_sat;
    logic [lfbp_pkg::CODE_W-1:0]  code_mask;
    logic [lfbp_pkg::ACC_W-1:0]   acc;
    logic [lfbp_pkg::ACC_W-1:0]   acc_rest;
    logic [lfbp_pkg::TOTAL_W-1:0] sym_pos;
    logic [lfbp_pkg::TOTAL_W-1:0] total;

    always_comb begin
        len_sat   = (i_item.bit_length > LenLimit) ? LenLimit : i_item.bit_length;
        code_mask = ~({lfbp_pkg::CODE_W{1'b1}} << len_sat);
        sym_pos   = lfbp_pkg::TOTAL_W'(r_pend_cnt) + len_sat;
        total     = sym_pos + lfbp_pkg::TOTAL_W'(lfbp_pkg::SYM_W);
        acc       = lfbp_pkg::ACC_W'(r_pend_bits)
                  | (lfbp_pkg::ACC_W'(i_item.code & code_mask) << r_pend_cnt)
                  | (lfbp_pkg::ACC_W'(i_item.sym) << sym_pos);
        acc_rest  = acc >> {total[lfbp_pkg::TOTAL_W-1:3], 3'b000};

        o_res.bytes = {acc[23:16], acc[15:8], acc[7:0]};
        o_res.nbytes = total[lfbp_pkg::TOTAL_W-1:3];
        n_pend_bits = acc_rest[lfbp_pkg::PEND_W-1:0];
        n_pend_cnt  = total[2:0];

        if (i_item.mode == lfbp_pkg::MODE_FLUSH) begin
            o_res.bytes  = {{(2*lfbp_pkg::BYTE_W){1'b0}}, 1'b0, r_pend_bits};
            o_res.nbytes = (r_pend_cnt != '0) ? 2'd1 : 2'd0;
            n_pend_bits  = '0;
            n_pend_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else if (i_load) begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && i_item.mode == lfbp_pkg::MODE_FLUSH |=> r_pend_cnt == '0 && r_pend_bits == '0)
        else $error("Pending bits remain after a flush.");

    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_bits >> r_pend_cnt) == '0)
        else $error("Pending bits above the pending count are not zero.");

endmodule

// ===== rtl/lfbp_out_buf.sv =====
// Result buffer: holds up to three packed bytes and sends them one per transfer.
module lfbp_out_buf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  lfbp_pkg::t_pack_res         i_res,
    input  logic                        i_stall,
    output logic                        o_free,
    output logic                        o_valid,
    output logic [lfbp_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_last
);

    logic [lfbp_pkg::MAX_BYTES-1:0][lfbp_pkg::BYTE_W-1:0] r_buf;
    logic [1:0] r_left;
    logic       out_fire;

    assign o_valid    = (r_left != 2'd0);
    assign o_out_byte = r_buf[0];
    assign o_last     = (r_left == 2'd1);
    assign out_fire   = o_valid && !i_stall;
    assign o_free     = (r_left == 2'd0) || (r_left == 2'd1 && out_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else if (i_load) begin
            r_left <= i_res.nbytes;
        end else if (out_fire) begin
            r_left <= r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_res.bytes;
        end else if (out_fire) begin
            r_buf <= {{lfbp_pkg::BYTE_W{1'b0}}, r_buf[2], r_buf[1]};
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> r_left == 2'd0 || (r_left == 2'd1 && out_fire))
        else $error("A new item overwrote bytes not yet sent.");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the LSB-first pair bit packer, with a scoreboard class.
`timescale 1ns / 100ps

module tb_top;

    class pack_scoreboard;
        logic [lfbp_pkg::BYTE_W-1:0] byte_q[$];
        logic                        last_q[$];
        logic [lfbp_pkg::PEND_W-1:0] held_bits;
        int                          held_count;
        bit                          failed;

        function new();
            held_bits  = '0;
            held_count = 0;
            failed     = 0;
        endfunction

        // Works out the bytes that one accepted input transfer must produce.
        function int note_transfer(logic mode, logic [lfbp_pkg::CODE_W-1:0] code,
                                   logic [lfbp_pkg::SYM_W-1:0] sym,
                                   logic [lfbp_pkg::LEN_W-1:0] bit_length);
            logic [31:0] acc;
            int          count;
            int          used_len;
            int          n;
            n = 0;
            if (mode == lfbp_pkg::MODE_FLUSH) begin
                if (held_count != 0) begin
                    byte_q.push_back({1'b0, held_bits});
                    last_q.push_back(1'b1);
                    n = 1;
                end
                held_bits  = '0;
                held_count = 0;
                return n;
            end
            used_len = (bit_length > lfbp_pkg::LEN_LIMIT) ? lfbp_pkg::LEN_LIMIT : bit_length;
            acc      = {25'd0, held_bits};
            acc     |= ({16'd0, code} & ((32'd1 << used_len) - 32'd1)) << held_count;
            count    = held_count + used_len;
            acc     |= {24'd0, sym} << count;
            count   += lfbp_pkg::SYM_W;
            while (count >= lfbp_pkg::BYTE_W) begin
                byte_q.push_back(acc[lfbp_pkg::BYTE_W-1:0]);
                last_q.push_back(count < 2 * lfbp_pkg::BYTE_W);
                acc   >>= lfbp_pkg::BYTE_W;
                count  -= lfbp_pkg::BYTE_W;
                n++;
            end
            held_count = count;
            held_bits  = acc[lfbp_pkg::PEND_W-1:0];
            return n;
        endfunction

        function void check_byte(logic [lfbp_pkg::BYTE_W-1:0] out_byte, logic last);
            logic [lfbp_pkg::BYTE_W-1:0] want_byte;
            logic                        want_last;
            if (byte_q.size() == 0) begin
                $error("unexpected transfer: out_byte %0h last %0b", out_byte, last);
                failed = 1;
                return;
            end
            want_byte = byte_q.pop_front();
            want_last = last_q.pop_front();
            if (out_byte !== want_byte) begin
                $error("out_byte mismatch: expected %0h, actual %0h", want_byte, out_byte);
                failed = 1;
            end
            if (last !== want_last) begin
                $error("last mismatch: expected %0b, actual %0b", want_last, last);
                failed = 1;
            end
        endfunction

        function int outstanding();
            return byte_q.size();
        endfunction
    endclass

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_valid      = 1'b0;
    logic                        i_mode       = lfbp_pkg::MODE_PAIR;
    logic [lfbp_pkg::CODE_W-1:0] i_code       = '0;
    logic [lfbp_pkg::SYM_W-1:0]  i_sym        = '0;
    logic [lfbp_pkg::LEN_W-1:0]  i_bit_length = '0;
    logic                        i_stall      = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic [lfbp_pkg::BYTE_W-1:0] o_out_byte;
    logic                        o_last;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    pack_scoreboard board = new();

    lsb_first_pair_bit_packer DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_code       (i_code),
        .i_sym        (i_sym),
        .i_bit_length (i_bit_length),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_byte(o_out_byte, o_last);
        end
    end

    task automatic send_item(input logic mode, input logic [lfbp_pkg::CODE_W-1:0] code,
                             input logic [lfbp_pkg::SYM_W-1:0] sym,
                             input logic [lfbp_pkg::LEN_W-1:0] bit_length,
                             output int produced);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_code       <= code;
        i_sym        <= sym;
        i_bit_length <= bit_length;
        do @(posedge i_clk); while (o_stall);
        produced = board.note_transfer(mode, code, sym, bit_length);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        int n;
        int produced;
        int phase;
        int r;
        logic                       mode;
        logic [lfbp_pkg::LEN_W-1:0] bit_length;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(lfbp_pkg::MODE_PAIR,  16'h0000, 8'h00, 5'd0,  n);
        send_item(lfbp_pkg::MODE_FLUSH, 16'hFFFF, 8'hFF, 5'd31, n);
        send_item(lfbp_pkg::MODE_PAIR,  16'hFFFF, 8'hFF, 5'd16, n);
        send_item(lfbp_pkg::MODE_PAIR,  16'hA5A5, 8'h3C, 5'd31, n);
        send_item(lfbp_pkg::MODE_PAIR,  16'h5A5A, 8'hC3, 5'd17, n);
        send_item(lfbp_pkg::MODE_PAIR,  16'h0001, 8'h80, 5'd1,  n);
        send_item(lfbp_pkg::MODE_FLUSH, 16'h0000, 8'h00, 5'd0,  n);
        send_item(lfbp_pkg::MODE_FLUSH, 16'h1234, 8'h56, 5'd9,  n);
        send_item(lfbp_pkg::MODE_PAIR,  16'h007F, 8'hFF, 5'd7,  n);
        send_item(lfbp_pkg::MODE_PAIR,  16'hFFFF, 8'hFF, 5'd16, n);
        send_item(lfbp_pkg::MODE_FLUSH, 16'hFFFF, 8'hFF, 5'd16, n);
        send_item(lfbp_pkg::MODE_PAIR,  16'hFFF8, 8'h00, 5'd3,  n);
        send_item(lfbp_pkg::MODE_FLUSH, 16'hFFFF, 8'hFF, 5'd31, n);
        send_item(lfbp_pkg::MODE_PAIR,  16'h5555, 8'h55, 5'd16, n);
        send_item(lfbp_pkg::MODE_PAIR,  16'hAAAA, 8'hAA, 5'd16, n);
        send_item(lfbp_pkg::MODE_PAIR,  16'hFFFF, 8'h00, 5'd15, n);
        send_item(lfbp_pkg::MODE_PAIR,  16'h0000, 8'hFF, 5'd16, n);
        send_item(lfbp_pkg::MODE_PAIR,  16'hFFFF, 8'h01, 5'd5,  n);
        send_item(lfbp_pkg::MODE_FLUSH, 16'h0000, 8'h00, 5'd0,  n);
        drain_results();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 48;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 48;
                end
                default: begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 36;
                end
            endcase
            produced = 0;
            while (produced < 50) begin
                mode = ($urandom_range(99) < 15) ? lfbp_pkg::MODE_FLUSH : lfbp_pkg::MODE_PAIR;
                r = $urandom_range(99);
                if (r < 8) begin
                    bit_length = lfbp_pkg::LEN_W'($urandom_range(31, 17));
                end else if (r < 16) begin
                    bit_length = ($urandom_range(1) != 0) ? 5'd16 : 5'd0;
                end else begin
                    bit_length = lfbp_pkg::LEN_W'($urandom_range(16, 0));
                end
                send_item(mode, lfbp_pkg::CODE_W'($urandom), lfbp_pkg::SYM_W'($urandom),
                          bit_length, n);
                if (n > 0) produced++;
            end
            drain_results();
        end

        if (board.failed) begin
            $display("simulation failed");
        end else begin
            $display("simulation ok");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/lfbp_pkg.sv
rtl/lfbp_pack.sv
rtl/lfbp_out_buf.sv
rtl/lsb_first_pair_bit_packer.sv
tb/tb_top.sv
